/* hdl/scan_bitmap_pixel_mapper_macros.svh */
// ----------------------------------------------------------------------------
// Scan bitmap pixel mapper assertion macros
// Assertion shorthands; each expands to one labeled concurrent check.
// ----------------------------------------------------------------------------
`ifndef SCAN_BITMAP_PIXEL_MAPPER_MACROS_SVH
`define SCAN_BITMAP_PIXEL_MAPPER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SBPM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in the next cycle that follows from a condition in this one.
`define SBPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition in the same cycle that follows from another one.
`define SBPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hdl/sbpm_pkg.sv */
// ----------------------------------------------------------------------------
// Scan bitmap pixel mapper package
// Frame geometry, field widths and the facet order and row offset tables.
// ----------------------------------------------------------------------------
package sbpm_pkg;

  // Horizontal resolution of one scan line in half pixels.
  localparam int LINE_WIDTH    = 1024;
  localparam int BYTES_PER_ROW = (LINE_WIDTH / 2 + 3) / 4;
  localparam int BIR_W         = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;

  localparam int ROW_SLOTS  = 8;
  localparam int TEXT_LINES = 3;
  localparam int SLOT_W     = 3;
  localparam int LINE_W     = 2;
  localparam int LINE_PITCH = 8 + 6;
  localparam int ASPECT     = 3;

  localparam int PAT_W = 8;
  localparam int X_W   = 11;
  localparam int Y_W   = 7;
  localparam int OFF_W = 7;

  localparam logic [PAT_W-1:0] PAIR_MASK = 8'hC0;

  typedef logic [SLOT_W-1:0]       row_idx_t;
  typedef logic signed [OFF_W-1:0] row_off_t;

  // Real row that each row slot of a text line scans, in facet order.
  localparam row_idx_t FACET_ORDER [TEXT_LINES][ROW_SLOTS] = '{
    '{3'd2, 3'd0, 3'd4, 3'd1, 3'd3, 3'd5, 3'd6, 3'd7},
    '{3'd2, 3'd1, 3'd0, 3'd4, 3'd3, 3'd6, 3'd5, 3'd7},
    '{3'd2, 3'd1, 3'd4, 3'd5, 3'd0, 3'd3, 3'd6, 3'd7}
  };

  // Horizontal offset of each real row, in half pixels.
  localparam row_off_t ROW_OFFSET [TEXT_LINES][ROW_SLOTS] = '{
    '{7'sd7,  7'sd41, 7'sd11, -7'sd16, -7'sd4, -7'sd6, -7'sd22, -7'sd5},
    '{-7'sd2, 7'sd4,  7'sd18, 7'sd14,  7'sd5,  7'sd25, 7'sd27,  7'sd14},
    '{7'sd7,  7'sd19, -7'sd2, 7'sd12,  7'sd8,  7'sd17, 7'sd17,  -7'sd4}
  };

  // Halve an offset, truncating toward zero.
  function automatic row_off_t half_toward_zero(input row_off_t v);
    row_off_t biased;
    biased = v + row_off_t'({{(OFF_W-1){1'b0}}, v[OFF_W-1]});
    return biased >>> 1;
  endfunction

endpackage

/* hdl/scan_bitmap_pixel_mapper.sv */
// A byte's first pixel passes from the work register into the output register.
// The single work register shifts out the four pixel pairs of a byte one pair a cycle,
// one pixel result per cycle while out_ready keeps the output register draining.
// The next byte is taken in the cycle its predecessor's fourth pixel moves on.
// Reset (rst_n, synchronous, active low) empties both registers and zeroes the
// byte, row slot and text line counters; payload registers are not reset.
// ----------------------------------------------------------------------------
// Scan bitmap pixel mapper
// Turns bitmap bytes of a laser display frame into lit flags with x/y positions.
// ----------------------------------------------------------------------------
`include "scan_bitmap_pixel_mapper_macros.svh"

module scan_bitmap_pixel_mapper (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel: one bitmap byte per transaction.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sbpm_pkg::PAT_W-1:0]      in_pattern_byte,
  // Result channel: one pixel per transaction, four per byte.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_lit,
  output logic signed [sbpm_pkg::X_W-1:0] out_x_pos,
  output logic [sbpm_pkg::Y_W-1:0]        out_y_pos,
  output logic                            out_last_of_byte,
  output logic                            out_frame_end
);

  // --------------------------------------------------------------------------
  // Frame position counters. They advance once per accepted byte and point at
  // the byte that the next transaction will carry.
  // --------------------------------------------------------------------------
  logic [sbpm_pkg::BIR_W-1:0]  byte_in_row_r, byte_in_row_nxt;
  logic [sbpm_pkg::SLOT_W-1:0] row_slot_r,    row_slot_nxt;
  logic [sbpm_pkg::LINE_W-1:0] text_line_r,   text_line_nxt;

  // Work register: the byte being split into pixels, with the position of the
  // pixel that goes out next. The pattern shifts left by one pair per pixel.
  logic                            wk_valid_r, wk_valid_nxt;
  logic [1:0]                      wk_k_r,     wk_k_nxt;
  logic [sbpm_pkg::PAT_W-1:0]      wk_pat_r,   wk_pat_nxt;
  logic signed [sbpm_pkg::X_W-1:0] wk_x_r,     wk_x_nxt;
  logic [sbpm_pkg::Y_W-1:0]        wk_y_r,     wk_y_nxt;
  logic                            wk_last_r,  wk_last_nxt;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_lit_r,   out_lit_nxt;
  logic signed [sbpm_pkg::X_W-1:0] out_x_r,     out_x_nxt;
  logic [sbpm_pkg::Y_W-1:0]        out_y_r,     out_y_nxt;
  logic                            out_lob_r,   out_lob_nxt;
  logic                            out_fe_r,    out_fe_nxt;

  logic                             wk_adv;
  logic                             in_acc;
  logic                             row_end;
  logic                             slot_end;
  logic [sbpm_pkg::SLOT_W-1:0]      real_row;
  logic signed [sbpm_pkg::OFF_W-1:0] half_off;
  logic [sbpm_pkg::X_W-1:0]         col_base;
  logic [sbpm_pkg::Y_W-1:0]         y_row;

  // The work register hands a pixel on whenever the output register is empty
  // or its pixel is being taken in this cycle.
  assign wk_adv = wk_valid_r && (!out_valid_r || out_ready);

  // A new byte enters when the work register is empty, or when the fourth
  // pixel of the current byte leaves it in this cycle.
  assign in_ready = !wk_valid_r || (wk_adv && (wk_k_r == 2'd3));
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Geometry of the byte being taken: facet order lookup, row offset halved
  // toward zero, column of its first pixel and the scaled y position.
  // --------------------------------------------------------------------------
  assign row_end  = (byte_in_row_r == sbpm_pkg::BIR_W'(sbpm_pkg::BYTES_PER_ROW - 1));
  assign slot_end = (row_slot_r == sbpm_pkg::SLOT_W'(sbpm_pkg::ROW_SLOTS - 1));

  assign real_row = sbpm_pkg::FACET_ORDER[text_line_r][row_slot_r];
  assign half_off = sbpm_pkg::half_toward_zero(sbpm_pkg::ROW_OFFSET[text_line_r][real_row]);

  // Column of the first pixel of the byte; it wraps modulo 2^11 on wide rows.
  assign col_base = sbpm_pkg::X_W'({byte_in_row_r, 2'b00});

  assign y_row = sbpm_pkg::Y_W'(real_row)
               + sbpm_pkg::Y_W'(text_line_r) * sbpm_pkg::Y_W'(sbpm_pkg::LINE_PITCH);

  always_comb begin
    byte_in_row_nxt = byte_in_row_r;
    row_slot_nxt    = row_slot_r;
    text_line_nxt   = text_line_r;
    if (in_acc) begin
      if (row_end) begin
        byte_in_row_nxt = '0;
        if (slot_end) begin
          row_slot_nxt = '0;
          if (text_line_r == sbpm_pkg::LINE_W'(sbpm_pkg::TEXT_LINES - 1)) begin
            text_line_nxt = '0;
          end else begin
            text_line_nxt = text_line_r + 1'b1;
          end
        end else begin
          row_slot_nxt = row_slot_r + 1'b1;
        end
      end else begin
        byte_in_row_nxt = byte_in_row_r + 1'b1;
      end
    end
  end

  // Work register: load on a new byte, otherwise step to the next pixel.
  always_comb begin
    wk_valid_nxt = wk_valid_r;
    wk_k_nxt     = wk_k_r;
    wk_pat_nxt   = wk_pat_r;
    wk_x_nxt     = wk_x_r;
    wk_y_nxt     = wk_y_r;
    wk_last_nxt  = wk_last_r;
    if (in_acc) begin
      wk_valid_nxt = 1'b1;
      wk_k_nxt     = 2'd0;
      wk_pat_nxt   = in_pattern_byte;
      wk_x_nxt     = $signed(col_base) - sbpm_pkg::X_W'(half_off);
      wk_y_nxt     = y_row * sbpm_pkg::Y_W'(sbpm_pkg::ASPECT);
      wk_last_nxt  = row_end && slot_end
                  && (text_line_r == sbpm_pkg::LINE_W'(sbpm_pkg::TEXT_LINES - 1));
    end else if (wk_adv) begin
      wk_k_nxt   = wk_k_r + 1'b1;
      wk_pat_nxt = {wk_pat_r[sbpm_pkg::PAT_W-3:0], 2'b00};
      wk_x_nxt   = wk_x_r + sbpm_pkg::X_W'(1);
      if (wk_k_r == 2'd3) begin
        wk_valid_nxt = 1'b0;
      end
    end
  end

  // Output register: takes the current pixel whenever the work register advances.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_lit_nxt   = out_lit_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_lob_nxt   = out_lob_r;
    out_fe_nxt    = out_fe_r;
    if (wk_adv) begin
      out_valid_nxt = 1'b1;
      out_lit_nxt   = |(wk_pat_r & sbpm_pkg::PAIR_MASK);
      out_x_nxt     = wk_x_r;
      out_y_nxt     = wk_y_r;
      out_lob_nxt   = (wk_k_r == 2'd3);
      out_fe_nxt    = (wk_k_r == 2'd3) && wk_last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r <= '0;
      row_slot_r    <= '0;
      text_line_r   <= '0;
      wk_valid_r    <= 1'b0;
      wk_k_r        <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      byte_in_row_r <= byte_in_row_nxt;
      row_slot_r    <= row_slot_nxt;
      text_line_r   <= text_line_nxt;
      wk_valid_r    <= wk_valid_nxt;
      wk_k_r        <= wk_k_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    wk_pat_r  <= wk_pat_nxt;
    wk_x_r    <= wk_x_nxt;
    wk_y_r    <= wk_y_nxt;
    wk_last_r <= wk_last_nxt;
    out_lit_r <= out_lit_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_lob_r <= out_lob_nxt;
    out_fe_r  <= out_fe_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_lit          = out_lit_r;
  assign out_x_pos        = out_x_r;
  assign out_y_pos        = out_y_r;
  assign out_last_of_byte = out_lob_r;
  assign out_frame_end    = out_fe_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `SBPM_ASSERT_SAME(a_fe_on_last, out_valid_r && out_fe_r, out_lob_r, "frame end off last pixel")
  `SBPM_ASSERT_SAME(a_load_on_fourth, in_acc && wk_valid_r, wk_adv && (wk_k_r == 2'd3),
                    "byte overwritten early")
  `SBPM_ASSERT_NEXT(a_load_starts, in_acc, wk_valid_r && (wk_k_r == 2'd0), "new byte not loaded")
  `SBPM_ASSERT_NEXT(a_x_steps, wk_adv && !in_acc && (wk_k_r != 2'd3),
                    wk_x_r == $past(wk_x_r) + sbpm_pkg::X_W'(1), "column did not step")
  `SBPM_ASSERT_ALWAYS(a_line_range, text_line_r != 2'd3, "text line counter out of range")

endmodule

/* bench/scan_bitmap_pixel_mapper_test.sv */
// ----------------------------------------------------------------------------
// Scan bitmap pixel mapper testbench
// Streams bitmap bytes into the mapper across several rows and row slots. Each
// accepted byte is turned into four expected pixels by a behavioral model
// inside the bench. Every pixel transaction on the result channel is checked
// field by field against the oldest expected pixel. The run goes through
// phases of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module scan_bitmap_pixel_mapper_test;

  // One pixel transaction as it should appear on the result channel.
  typedef struct {
    logic                            lit;
    logic signed [sbpm_pkg::X_W-1:0] x_pos;
    logic [sbpm_pkg::Y_W-1:0]        y_pos;
    logic                            last_of_byte;
    logic                            frame_end;
  } pixel_t;

  // Bytes per traffic phase. Four phases of this size carry the stream across
  // two row boundaries, so the row slot counter and facet lookup move.
  localparam int PHASE_BYTES  = 93;
  localparam int NUM_PHASES   = 4;
  localparam int TOTAL_BYTES  = NUM_PHASES * PHASE_BYTES;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 16;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [sbpm_pkg::PAT_W-1:0]      in_pattern_byte = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_lit;
  logic signed [sbpm_pkg::X_W-1:0] out_x_pos;
  logic [sbpm_pkg::Y_W-1:0]        out_y_pos;
  logic                            out_last_of_byte;
  logic                            out_frame_end;

  logic [sbpm_pkg::PAT_W-1:0] pending_bytes [$];
  pixel_t                     expected_pixels [$];

  // Scan position as the bench believes the mapper holds it.
  int scan_byte;
  int scan_slot;
  int scan_line;

  int bytes_taken;
  int pixels_seen;
  int mismatch_count;
  int cycle_count;

  scan_bitmap_pixel_mapper u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pattern_byte  (in_pattern_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lit          (out_lit),
    .out_x_pos        (out_x_pos),
    .out_y_pos        (out_y_pos),
    .out_last_of_byte (out_last_of_byte),
    .out_frame_end    (out_frame_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The traffic phase follows the number of bytes taken so far: phase 0 runs
  // without gaps, phase 1 idles the sender, phase 2 stalls the receiver and
  // phase 3 idles both sides at a lighter rate.
  function automatic int traffic_phase();
    int p;
    p = bytes_taken / PHASE_BYTES;
    return (p >= NUM_PHASES) ? NUM_PHASES - 1 : p;
  endfunction

  function automatic bit sender_idles();
    int pct;
    pct = (traffic_phase() == 1) ? 82 : (traffic_phase() == 3) ? 29 : 0;
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic bit receiver_stalls();
    int pct;
    pct = (traffic_phase() == 2) ? 82 : (traffic_phase() == 3) ? 29 : 0;
    return $urandom_range(99, 0) < pct;
  endfunction

  // Expands one bitmap byte into its four pixels at the current scan
  // position, then steps the byte, row slot and text line counters.
  task automatic queue_pixels_for(input logic [sbpm_pkg::PAT_W-1:0] pattern);
    logic [sbpm_pkg::PAT_W-1:0] pairs;
    pixel_t                     pix;
    int                         real_row;
    int                         half_off;
    int                         column;
    int                         y_full;
    bit                         final_byte;
    pairs = pattern;
    // The row slot selects a real row through the facet order of this line;
    // the offset table is indexed by that real row, not by the slot.
    real_row = sbpm_pkg::FACET_ORDER[scan_line][scan_slot];
    // Integer division in SystemVerilog truncates toward zero, which is the
    // rounding the offset correction calls for (-5 halves to -2, not -3).
    half_off = int'(sbpm_pkg::ROW_OFFSET[scan_line][real_row]) / 2;
    y_full = (real_row + scan_line * sbpm_pkg::LINE_PITCH) * sbpm_pkg::ASPECT;
    final_byte = (scan_byte + 1 >= sbpm_pkg::BYTES_PER_ROW) &&
                 (scan_slot == sbpm_pkg::ROW_SLOTS - 1) &&
                 (scan_line == sbpm_pkg::TEXT_LINES - 1);
    for (int k = 0; k < 4; k++) begin
      column = scan_byte * 4 + k - half_off;
      pix.lit          = |pairs[sbpm_pkg::PAT_W-1 -: 2];
      pix.x_pos        = column[sbpm_pkg::X_W-1:0];
      pix.y_pos        = y_full[sbpm_pkg::Y_W-1:0];
      pix.last_of_byte = (k == 3);
      pix.frame_end    = (k == 3) && final_byte;
      expected_pixels.push_back(pix);
      pairs = pairs << 2;
    end
    scan_byte++;
    if (scan_byte >= sbpm_pkg::BYTES_PER_ROW) begin
      scan_byte = 0;
      scan_slot++;
      if (scan_slot >= sbpm_pkg::ROW_SLOTS) begin
        scan_slot = 0;
        scan_line++;
        if (scan_line >= sbpm_pkg::TEXT_LINES) begin
          scan_line = 0;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatch_count++;
    $display("mismatch: pixel %0d field %s got %0d expected %0d", pixels_seen, field, got,
             want);
  endtask

  // Byte driver. An accepted byte is predicted at the edge that accepts it,
  // using the payload that was on the port at that edge. A byte that is not
  // yet accepted stays on the port untouched; otherwise the next one is
  // offered unless the sender takes a gap this cycle.
  always @(posedge clk) begin : drive_bytes
    bit accepted;
    accepted = in_valid && in_ready;
    if (accepted) begin
      queue_pixels_for(in_pattern_byte);
      bytes_taken++;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accepted) begin
      if (pending_bytes.size() != 0 && !sender_idles()) begin
        in_pattern_byte <= pending_bytes.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pixel monitor. Outputs are sampled at the edge before the mapper's own
  // updates land, so each accepted transaction is seen exactly once.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_lit !== want.lit) begin
          report_mismatch("lit", out_lit, want.lit);
        end
        if (out_x_pos !== want.x_pos) begin
          report_mismatch("x_pos", int'(out_x_pos), int'(want.x_pos));
        end
        if (out_y_pos !== want.y_pos) begin
          report_mismatch("y_pos", out_y_pos, want.y_pos);
        end
        if (out_last_of_byte !== want.last_of_byte) begin
          report_mismatch("last_of_byte", out_last_of_byte, want.last_of_byte);
        end
        if (out_frame_end !== want.frame_end) begin
          report_mismatch("frame_end", out_frame_end, want.frame_end);
        end
      end
      pixels_seen++;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_stalls();
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [sbpm_pkg::PAT_W-1:0] b;
    // Directed bytes first: all dark, all lit, each pair alone with both of
    // its bits, each single bit, and alternating patterns. They also start
    // at the very beginning of a row, where the offset correction can push
    // x below zero.
    pending_bytes = '{8'h00, 8'hFF, 8'hC0, 8'h30, 8'h0C, 8'h03, 8'h80, 8'h40,
                      8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'hAA, 8'h55,
                      8'h00, 8'hFF};
    // Random bytes: half uniform, a quarter with one lit pair, a quarter all
    // dark or all lit.
    while (pending_bytes.size() < TOTAL_BYTES) begin
      case ($urandom_range(3, 0))
        0, 1: b = sbpm_pkg::PAT_W'($urandom_range(255, 0));
        2: b = sbpm_pkg::PAT_W'($urandom_range(3, 1) << (2 * $urandom_range(3, 0)));
        default: b = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      endcase
      pending_bytes.push_back(b);
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Wait until every byte has been taken and every pixel has come back.
    while (bytes_taken < TOTAL_BYTES || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    // Give the mapper's pipeline time to show any extra pixel.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/sbpm_pkg.sv
hdl/scan_bitmap_pixel_mapper.sv
bench/scan_bitmap_pixel_mapper_test.sv
